/* hw/rtl/rolling_hash_phrase_splitter_top_defines.svh */
// assertion macros for the rolling hash phrase splitter
`ifndef ROLLING_HASH_PHRASE_SPLITTER_TOP_DEFINES_SVH
`define ROLLING_HASH_PHRASE_SPLITTER_TOP_DEFINES_SVH

`define RHPS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhps check failed");

`define RHPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhps check failed");

`endif

/* hw/rtl/rhps_pkg.sv */
// shared types, constants and modular helpers for the phrase splitter
package rhps_pkg;

  localparam logic [30:0] KR_PRIME  = 31'd1999999973;
  localparam logic [7:0]  END_MARK  = 8'd36;
  localparam logic [7:0]  BAD_LIMIT = 8'd2;
  localparam logic [6:0]  WS_RESET  = 7'd10;
  localparam logic [6:0]  WS_MIN    = 7'd4;
  localparam logic [30:0] MOD_RESET = 31'd100;
  localparam logic [30:0] MOD_MIN   = 31'd10;

  localparam logic [1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [1:0] CFG_MODULUS     = 2'd1;

  localparam logic [1:0] BND_NONE = 2'd0;
  localparam logic [1:0] BND_HASH = 2'd1;
  localparam logic [1:0] BND_SEQ  = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_END,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [30:0] rolling_hash;
    logic [1:0]  boundary;
    logic [15:0] phrase_length;
    logic [47:0] end_position;
    logic [31:0] sequence_number;
    logic        bad_byte;
  } result_t;

  function automatic logic [30:0] mod_dbl(input logic [30:0] a);
    logic [31:0] t;
    t = {a, 1'b0};
    if (t >= {1'b0, KR_PRIME}) begin
      t = t - {1'b0, KR_PRIME};
    end
    return t[30:0];
  endfunction

  function automatic logic [30:0] mod_add(input logic [30:0] a, input logic [30:0] b);
    logic [31:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, KR_PRIME}) begin
      t = t - {1'b0, KR_PRIME};
    end
    return t[30:0];
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

/* hw/rtl/rhps_front.sv */
// input queue that classifies each byte request
module rhps_front
  import rhps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_byte_in,
  output logic       in_full,
  output logic       item_valid,
  output item_t      item,
  input  logic       item_take
);

  item_t          q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           push_ok;
  logic           pop_ok;
  item_t          new_item;

  assign in_full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rd_ptr_r];
  assign push_ok    = in_push && !in_full;
  assign pop_ok     = item_take && item_valid;

  always_comb begin
    new_item.data = in_byte_in;
    if (in_byte_in <= BAD_LIMIT) begin
      new_item.kind = KIND_BAD;
    end else if (in_byte_in == END_MARK) begin
      new_item.kind = KIND_END;
    end else begin
      new_item.kind = KIND_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + (QAW+1)'(1);
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - (QAW+1)'(1);
      end
    end
  end

endmodule

/* hw/rtl/rhps_weight.sv */
// outgoing weight unit, 256^(w-1) mod prime by repeated doubling
module rhps_weight
  import rhps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [6:0]  win,
  output logic        busy,
  output logic [30:0] weight
);

  logic [30:0] p_r;
  logic [6:0]  cnt_r;
  logic [2:0]  step_r;
  logic        busy_r;

  assign busy   = busy_r;
  assign weight = p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r    <= 31'd1;
      cnt_r  <= WS_RESET - 7'd1;
      step_r <= '0;
      busy_r <= 1'b1;
    end else if (start) begin
      p_r    <= 31'd1;
      cnt_r  <= win - 7'd1;
      step_r <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      p_r    <= mod_dbl(p_r);
      step_r <= step_r + 3'd1;
      if (step_r == 3'd7) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

/* hw/rtl/rhps_back.sv */
// sequencer that updates the window hash, runs the cut test and holds the result
module rhps_back
  import rhps_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  item_t       item,
  output logic        item_take,
  input  logic [6:0]  window_size,
  input  logic [30:0] modulus,
  input  logic [30:0] weight,
  input  logic        weight_busy,
  output logic        res_valid,
  output result_t     res,
  input  logic        res_pop
);

  localparam int SW = $clog2(WINDOW_MAX);
  localparam int CW = (SW + 1 > 7) ? SW + 1 : 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUB,
    S_SHL,
    S_ADDC,
    S_DIV,
    S_FIN
  } state_t;

  state_t          st_r;
  item_t           cur_r;
  logic [SW-1:0]   slot_r;
  logic [SW-1:0]   k_r;
  logic [SW-1:0]   k_c;
  logic [7:0]      store_r [WINDOW_MAX];
  logic [CW-1:0]   fill_r;
  logic [7:0]      rd_r;
  logic            old_vld_r;
  logic [7:0]      old_byte;
  logic [30:0]     acc_r;
  logic [2:0]      bit_r;
  logic [4:0]      dbit_r;
  logic [30:0]     rem_r;
  logic [31:0]     rem_t;
  logic [30:0]     hash_r;
  logic [15:0]     plen_r;
  logic [47:0]     pos_r;
  logic [31:0]     seq_r;
  logic            atstart_r;
  logic            res_valid_r;
  result_t         res_r;
  logic            dispatch;
  logic            fin_go;
  logic [CW-1:0]   ws_ext;
  logic [15:0]     pl_inc;
  logic            cut;
  result_t         res_nxt;

  assign ws_ext    = CW'(window_size);
  assign k_c       = (CW'(slot_r) >= ws_ext) ? '0 : slot_r;
  assign dispatch  = (st_r == S_IDLE) && item_valid && !weight_busy;
  assign item_take = dispatch;
  assign fin_go    = (st_r == S_FIN) && (!res_valid_r || res_pop);
  assign old_byte  = old_vld_r ? rd_r : 8'd0;
  assign rem_t     = {rem_r, acc_r[dbit_r]};
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign pl_inc    = sat_inc(plen_r);
  assign cut       = (rem_r == '0) && (pl_inc > 16'(window_size));

  always_comb begin
    res_nxt.rolling_hash    = hash_r;
    res_nxt.boundary        = BND_NONE;
    res_nxt.phrase_length   = '0;
    res_nxt.end_position    = pos_r;
    res_nxt.sequence_number = seq_r + 32'd1;
    res_nxt.bad_byte        = 1'b0;
    case (cur_r.kind)
      KIND_BAD: begin
        res_nxt.bad_byte = 1'b1;
      end
      KIND_END: begin
        res_nxt.end_position  = pos_r + 48'd1;
        res_nxt.boundary      = BND_SEQ;
        res_nxt.phrase_length = sat_inc(atstart_r ? 16'd1 : plen_r);
      end
      KIND_DATA: begin
        res_nxt.end_position = pos_r + 48'd1;
        res_nxt.rolling_hash = acc_r;
        if (!atstart_r && cut) begin
          res_nxt.boundary      = BND_HASH;
          res_nxt.phrase_length = pl_inc;
        end
      end
      default: begin
        res_nxt.bad_byte = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dispatch) begin
      rd_r <= store_r[k_c];
    end
    if (fin_go && (cur_r.kind == KIND_DATA)) begin
      store_r[k_r] <= cur_r.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      hash_r      <= '0;
      plen_r      <= '0;
      pos_r       <= '0;
      seq_r       <= '0;
      atstart_r   <= 1'b1;
      res_valid_r <= 1'b0;
    end else begin
      if (res_pop && res_valid_r && !fin_go) begin
        res_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (CW'(slot_r) >= ws_ext) begin
            slot_r <= '0;
          end
          if (dispatch) begin
            cur_r     <= item;
            k_r       <= k_c;
            old_vld_r <= (CW'(k_c) < fill_r);
            acc_r     <= '0;
            bit_r     <= '0;
            st_r      <= (item.kind == KIND_DATA) ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          acc_r <= mod_add(mod_dbl(acc_r), old_byte[3'd7 - bit_r] ? weight : 31'd0);
          bit_r <= bit_r + 3'd1;
          if (bit_r == 3'd7) begin
            st_r <= S_SUB;
          end
        end
        S_SUB: begin
          acc_r <= mod_add(hash_r, KR_PRIME - acc_r);
          bit_r <= '0;
          st_r  <= S_SHL;
        end
        S_SHL: begin
          acc_r <= mod_dbl(acc_r);
          bit_r <= bit_r + 3'd1;
          if (bit_r == 3'd7) begin
            st_r <= S_ADDC;
          end
        end
        S_ADDC: begin
          acc_r  <= mod_add(acc_r, {23'd0, cur_r.data});
          rem_r  <= '0;
          dbit_r <= 5'd30;
          st_r   <= S_DIV;
        end
        S_DIV: begin
          if (rem_t >= {1'b0, modulus}) begin
            rem_r <= 31'(rem_t - {1'b0, modulus});
          end else begin
            rem_r <= rem_t[30:0];
          end
          dbit_r <= dbit_r - 5'd1;
          if (dbit_r == 5'd0) begin
            st_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            res_r       <= res_nxt;
            res_valid_r <= 1'b1;
            st_r        <= S_IDLE;
            case (cur_r.kind)
              KIND_END: begin
                pos_r     <= pos_r + 48'd1;
                seq_r     <= seq_r + 32'd1;
                fill_r    <= '0;
                slot_r    <= '0;
                hash_r    <= '0;
                plen_r    <= '0;
                atstart_r <= 1'b1;
              end
              KIND_DATA: begin
                pos_r          <= pos_r + 48'd1;
                hash_r         <= acc_r;
                if (CW'(k_r) == fill_r) begin
                  fill_r <= fill_r + CW'(1);
                end
                slot_r         <= (CW'(k_r) + CW'(1) >= ws_ext) ? '0 : k_r + SW'(1);
                atstart_r      <= 1'b0;
                if (atstart_r) begin
                  plen_r <= 16'd2;
                end else if (cut) begin
                  plen_r <= 16'(window_size);
                end else begin
                  plen_r <= pl_inc;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/rolling_hash_phrase_splitter_top.sv */
// top level of the rolling hash phrase splitter
//
//  channel  ports                       request accepted when
//  in       in_push / in_full           in_push && !in_full
//  out      out_pop / out_empty         out_pop && !out_empty
//  cfg      cfg_valid / cfg_ready       cfg_valid && cfg_ready
//
// a text byte passes through the back sequencer as 8 multiply steps, one subtract, 8 shift
// steps, one add, 31 remainder steps and a finish step; '$' and bad bytes go straight to finish
// the front queue holds 4 requests and keeps taking bytes, until full, while the back works or stalls
// after reset the weight unit computes the weight for the reset window size before the first byte is started
// a window_size write holds cfg_ready low while the weight unit recomputes the weight
module rolling_hash_phrase_splitter_top
  import rhps_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_byte_in,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [30:0] out_rolling_hash,
  output logic [1:0]  out_boundary,
  output logic [15:0] out_phrase_length,
  output logic [47:0] out_end_position,
  output logic [31:0] out_sequence_number,
  output logic        out_bad_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  `include "rolling_hash_phrase_splitter_top_defines.svh"

  localparam logic [6:0] WS_CAP = (WINDOW_MAX > 127) ? 7'd127 : 7'(WINDOW_MAX);

  logic [6:0]  window_size_r;
  logic [30:0] modulus_r;
  logic [6:0]  ws_clamp;
  logic        cfg_go;
  logic        ws_start;
  logic        wbusy;
  logic [30:0] weight;
  logic        item_valid;
  item_t       item;
  logic        item_take;
  logic        res_valid;
  result_t     res;

  assign cfg_ready = !wbusy;
  assign cfg_go    = cfg_valid && cfg_ready;
  assign ws_start  = cfg_go && (cfg_index == CFG_WINDOW_SIZE);

  always_comb begin
    ws_clamp = cfg_wdata[6:0];
    if (ws_clamp < WS_MIN) begin
      ws_clamp = WS_MIN;
    end else if (ws_clamp > WS_CAP) begin
      ws_clamp = WS_CAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WS_RESET;
      modulus_r     <= MOD_RESET;
    end else if (cfg_go) begin
      case (cfg_index)
        CFG_WINDOW_SIZE: window_size_r <= ws_clamp;
        CFG_MODULUS: begin
          modulus_r <= (cfg_wdata < MOD_MIN) ? MOD_MIN : cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  rhps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_byte_in (in_byte_in),
    .in_full    (in_full),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  rhps_weight u_weight (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ws_start),
    .win    (ws_clamp),
    .busy   (wbusy),
    .weight (weight)
  );

  rhps_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take),
    .window_size (window_size_r),
    .modulus     (modulus_r),
    .weight      (weight),
    .weight_busy (wbusy),
    .res_valid   (res_valid),
    .res         (res),
    .res_pop     (out_pop)
  );

  assign out_empty           = !res_valid;
  assign out_rolling_hash    = res.rolling_hash;
  assign out_boundary        = res.boundary;
  assign out_phrase_length   = res.phrase_length;
  assign out_end_position    = res.end_position;
  assign out_sequence_number = res.sequence_number;
  assign out_bad_byte        = res.bad_byte;

  `RHPS_ASSERT_IMPL(a_hash_reduced, !out_empty, out_rolling_hash < KR_PRIME)
  `RHPS_ASSERT_IMPL(a_bad_no_cut, !out_empty && out_bad_byte,
    out_boundary == BND_NONE && out_phrase_length == 16'd0)
  `RHPS_ASSERT_IMPL(a_len_only_at_end, !out_empty && out_boundary == BND_NONE,
    out_phrase_length == 16'd0)

endmodule
